// ===== sv/urbx_pkg.sv =====
package urbx_pkg;

	localparam logic [1:0] OP_LINE  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [7:0] CH_XON  = 8'h11;
	localparam logic [7:0] CH_XOFF = 8'h13;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the incoming item
		logic update;    // commit queue state, write stores
		logic read;      // read the stores at the latched addresses
		logic load_out;  // move the result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;  // output register is empty or being taken now
	} sts_t;

endpackage

// ===== sv/uart_ring_buffer_xon_xoff.sv =====
// Each input transfer passes through the queue update, the store read and the output
// load, each registered; the output load waits until the output register is free, and
// the result then waits there until transferred. The controller takes one item at a time,
// taking the next one after the output load, while the previous result still waits.
// Reset: arst_n clears both queues to empty, overflow and pause to 0, transmitter idle.
module uart_ring_buffer_xon_xoff
	import urbx_pkg::*;
#(
	parameter int RX_DEPTH = 16,
	parameter int TX_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       operation,
	input  logic                             rx_valid,
	input  logic                             tx_done,
	input  logic [7:0]                       data_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             status,
	output logic [7:0]                       read_data,
	output logic                             tx_load,
	output logic [7:0]                       tx_byte,
	output logic                             overflow,
	output logic                             paused,
	output logic [$clog2(RX_DEPTH + 1)-1:0]  rx_count,
	output logic [$clog2(TX_DEPTH + 1)-1:0]  tx_count
);

	cmd_t cmd;
	sts_t sts;

	urbx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	urbx_dp #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.operation (operation),
		.rx_valid  (rx_valid),
		.tx_done   (tx_done),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.read_data (read_data),
		.tx_load   (tx_load),
		.tx_byte   (tx_byte),
		.overflow  (overflow),
		.paused    (paused),
		.rx_count  (rx_count),
		.tx_count  (tx_count)
	);

endmodule

// ===== sv/urbx_ctrl.sv =====
module urbx_ctrl
	import urbx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_UPD  = 2'd1;
	localparam logic [1:0] S_RD   = 2'd2;
	localparam logic [1:0] S_WB   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_n;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_n      = state_q;
		cmd.capture  = 1'b0;
		cmd.update   = 1'b0;
		cmd.read     = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = S_UPD;
				end
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_n    = S_RD;
			end
			S_RD: begin
				cmd.read = 1'b1;
				state_n  = S_WB;
			end
			S_WB: begin
				// hold until the previous result has left
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

// ===== sv/urbx_dp.sv =====
module urbx_dp
	import urbx_pkg::*;
#(
	parameter int RX_DEPTH = 16,
	parameter int TX_DEPTH = 16,
	localparam int RPW = $clog2(RX_DEPTH),
	localparam int RLW = $clog2(RX_DEPTH + 1),
	localparam int TPW = $clog2(TX_DEPTH),
	localparam int TLW = $clog2(TX_DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cmd_t           cmd,
	output sts_t           sts,
	input  logic [1:0]     operation,
	input  logic           rx_valid,
	input  logic           tx_done,
	input  logic [7:0]     data_in,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           status,
	output logic [7:0]     read_data,
	output logic           tx_load,
	output logic [7:0]     tx_byte,
	output logic           overflow,
	output logic           paused,
	output logic [RLW-1:0] rx_count,
	output logic [TLW-1:0] tx_count
);

	localparam int RSW = RLW + 1;
	localparam int TSW = TLW + 1;

	// latched item
	logic [1:0] op_q;
	logic       rxv_q;
	logic       txd_q;
	logic [7:0] data_q;

	// queue state
	logic [RPW-1:0] rx_wptr_q;
	logic [RLW-1:0] rx_level_q;
	logic           ovf_q;
	logic           paused_q;
	logic [TPW-1:0] tx_rptr_q;
	logic [TLW-1:0] tx_level_q;
	logic           idle_q;

	// per-item results waiting for the store reads
	logic           status_q;
	logic           rd_ok_q;
	logic           load_q;
	logic [RPW-1:0] rx_raddr_q;
	logic [TPW-1:0] tx_raddr_q;
	logic [7:0]     rx_rd_q;
	logic [7:0]     tx_rd_q;

	logic [7:0] rx_mem [RX_DEPTH];
	logic [7:0] tx_mem [TX_DEPTH];

	// output register
	logic           out_valid_q;
	logic           o_status_q;
	logic [7:0]     o_rdata_q;
	logic           o_load_q;
	logic [7:0]     o_tbyte_q;
	logic           o_ovf_q;
	logic           o_paused_q;
	logic [RLW-1:0] o_rx_count_q;
	logic [TLW-1:0] o_tx_count_q;

	// next state
	logic [RPW-1:0] rx_wptr_n;
	logic [RLW-1:0] rx_level_n;
	logic           ovf_n;
	logic           paused_n;
	logic [TPW-1:0] tx_rptr_n;
	logic [TLW-1:0] tx_level_n;
	logic           idle_n;
	logic           rx_we;
	logic           tx_we;
	logic           status_n;
	logic           rd_ok_n;
	logic           kick;
	logic           start;

	logic [TSW-1:0] tx_wsum;
	logic [TPW-1:0] tx_waddr;
	logic [RSW-1:0] rx_hsum;
	logic [RPW-1:0] rx_head;

	// tail of the transmit queue: read pointer plus level, wrapped
	assign tx_wsum  = TSW'(tx_rptr_q) + TSW'(tx_level_q);
	assign tx_waddr = (tx_wsum >= TSW'(TX_DEPTH)) ? TPW'(tx_wsum - TSW'(TX_DEPTH))
		: TPW'(tx_wsum);

	// head of the receive queue: write pointer minus level, wrapped
	assign rx_hsum = RSW'(rx_wptr_q) + RSW'(RX_DEPTH) - RSW'(rx_level_q);
	assign rx_head = (rx_hsum >= RSW'(RX_DEPTH)) ? RPW'(rx_hsum - RSW'(RX_DEPTH))
		: RPW'(rx_hsum);

	always_comb begin
		rx_wptr_n  = rx_wptr_q;
		rx_level_n = rx_level_q;
		ovf_n      = ovf_q;
		paused_n   = paused_q;
		tx_rptr_n  = tx_rptr_q;
		tx_level_n = tx_level_q;
		idle_n     = idle_q;
		rx_we      = 1'b0;
		tx_we      = 1'b0;
		status_n   = 1'b0;
		rd_ok_n    = 1'b0;
		kick       = 1'b0;
		case (op_q)
			OP_LINE: begin
				kick = txd_q;
				if (rxv_q) begin
					if (data_q == CH_XOFF) begin
						paused_n = 1'b1;
					end else if (data_q == CH_XON) begin
						paused_n = 1'b0;
						kick     = 1'b1;
					end else begin
						rx_we     = 1'b1;
						rx_wptr_n = (rx_wptr_q == RPW'(RX_DEPTH - 1)) ? '0
							: rx_wptr_q + 1'b1;
						// full: overwrite the oldest byte, keep the count
						if (rx_level_q == RLW'(RX_DEPTH)) begin
							ovf_n = 1'b1;
						end else begin
							rx_level_n = rx_level_q + 1'b1;
						end
					end
				end
				if (txd_q) begin
					idle_n = 1'b1;
				end
			end
			OP_WRITE: begin
				if (tx_level_q == TLW'(TX_DEPTH)) begin
					status_n = 1'b1;
				end else begin
					tx_we      = 1'b1;
					tx_level_n = tx_level_q + 1'b1;
					kick       = 1'b1;
				end
			end
			OP_READ: begin
				if (rx_level_q == '0) begin
					status_n = 1'b1;
				end else begin
					rd_ok_n    = 1'b1;
					rx_level_n = rx_level_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
		start = kick && idle_n && !paused_n && (tx_level_n != '0);
		if (start) begin
			tx_rptr_n  = (tx_rptr_q == TPW'(TX_DEPTH - 1)) ? '0 : tx_rptr_q + 1'b1;
			tx_level_n = tx_level_n - 1'b1;
			idle_n     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wptr_q   <= '0;
			rx_level_q  <= '0;
			ovf_q       <= 1'b0;
			paused_q    <= 1'b0;
			tx_rptr_q   <= '0;
			tx_level_q  <= '0;
			idle_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				rx_wptr_q  <= rx_wptr_n;
				rx_level_q <= rx_level_n;
				ovf_q      <= ovf_n;
				paused_q   <= paused_n;
				tx_rptr_q  <= tx_rptr_n;
				tx_level_q <= tx_level_n;
				idle_q     <= idle_n;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= operation;
			rxv_q  <= rx_valid;
			txd_q  <= tx_done;
			data_q <= data_in;
		end
		if (cmd.update) begin
			status_q   <= status_n;
			rd_ok_q    <= rd_ok_n;
			load_q     <= start;
			rx_raddr_q <= rx_head;
			tx_raddr_q <= tx_rptr_q;
			if (rx_we) begin
				rx_mem[rx_wptr_q] <= data_q;
			end
			if (tx_we) begin
				tx_mem[tx_waddr] <= data_q;
			end
		end
		// stores were written in the cycle before, so a fresh byte reads back here
		if (cmd.read) begin
			rx_rd_q <= rx_mem[rx_raddr_q];
			tx_rd_q <= tx_mem[tx_raddr_q];
		end
		if (cmd.load_out) begin
			o_status_q   <= status_q;
			o_rdata_q    <= rd_ok_q ? rx_rd_q : 8'h00;
			o_load_q     <= load_q;
			o_tbyte_q    <= load_q ? tx_rd_q : 8'h00;
			o_ovf_q      <= ovf_q;
			o_paused_q   <= paused_q;
			o_rx_count_q <= rx_level_q;
			o_tx_count_q <= tx_level_q;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign status    = o_status_q;
	assign read_data = o_rdata_q;
	assign tx_load   = o_load_q;
	assign tx_byte   = o_tbyte_q;
	assign overflow  = o_ovf_q;
	assign paused    = o_paused_q;
	assign rx_count  = o_rx_count_q;
	assign tx_count  = o_tx_count_q;

endmodule

// ===== sv/urbx_checker.sv =====
module urbx_checker #(
	parameter int RX_DEPTH = 16,
	parameter int TX_DEPTH = 16
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            status,
	input logic [7:0]                      read_data,
	input logic                            tx_load,
	input logic [7:0]                      tx_byte,
	input logic                            paused,
	input logic [$clog2(RX_DEPTH + 1)-1:0] rx_count,
	input logic [$clog2(TX_DEPTH + 1)-1:0] tx_count
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(tx_byte)
		&& $stable(status))
		else $error("result changed while stalled");

	// a refused host access neither reads nor starts the transmitter
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> read_data == 8'h00 && !tx_load)
		else $error("refused item carried data");

	// a byte is never handed over while paused
	a_no_load_paused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_load |-> !paused)
		else $error("transmit start while paused");

	// counts never pass their depths
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rx_count <= ($clog2(RX_DEPTH + 1))'(RX_DEPTH)
		&& tx_count <= ($clog2(TX_DEPTH + 1))'(TX_DEPTH))
		else $error("queue count out of range");

endmodule

bind uart_ring_buffer_xon_xoff urbx_checker #(
	.RX_DEPTH (RX_DEPTH),
	.TX_DEPTH (TX_DEPTH)
) u_urbx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.read_data (read_data),
	.tx_load   (tx_load),
	.tx_byte   (tx_byte),
	.paused    (paused),
	.rx_count  (rx_count),
	.tx_count  (tx_count)
);
